// File: rtl/direct_access_symbol_table_top_assert.svh
// ============================================================================
// Assertion macros for the direct-address symbol table
// Clocked property wrappers; each expects clk and rst_n in scope.
// ============================================================================
`ifndef DIRECT_ACCESS_SYMBOL_TABLE_TOP_ASSERT_SVH
`define DIRECT_ACCESS_SYMBOL_TABLE_TOP_ASSERT_SVH

// checked outside reset only
`define DAST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DAST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dast_pkg.sv
// ============================================================================
// dast_pkg
// Shared types and constants of the direct-address symbol table.
// ============================================================================
`default_nettype none

package dast_pkg;

    localparam int DEFAULT_SLOTS      = 64;
    localparam int DEFAULT_VALUE_BITS = 32;

    localparam int FUNC_BITS       = 2;
    localparam int KEY_BITS        = 6;
    localparam int VALUE_PORT_BITS = 32;
    localparam int RANK_BITS       = 6;
    localparam int OCC_BITS        = 7;
    localparam int GROUP_BITS      = 8;

    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 48;

    localparam int KEY_LSB   = 0;
    localparam int VALUE_LSB = KEY_LSB + KEY_BITS;
    localparam int RANK_LSB  = VALUE_LSB + VALUE_PORT_BITS;
    localparam int OCC_LSB   = VALUE_LSB + VALUE_PORT_BITS;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_SELECT = 2'd3
    } func_t;

    typedef struct packed {
        logic                done;
        logic                found;
        logic [KEY_BITS-1:0] key;
    } sel_res_t;

endpackage

`default_nettype wire

// File: rtl/dast_rank.sv
// ============================================================================
// dast_rank
// Rank select over the full marks: group popcounts, group walk, bit walk.
// ============================================================================
`default_nettype none

module dast_rank #(
    parameter int LIVE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [LIVE-1:0]                full,
    input  logic [dast_pkg::RANK_BITS-1:0] rank,
    output dast_pkg::sel_res_t             res
);
    import dast_pkg::*;

    localparam int NG   = (LIVE + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PW   = NG * GROUP_BITS;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int CNTW = $clog2(GROUP_BITS + 1);
    localparam int SUBW = $clog2(GROUP_BITS);

    logic [PW-1:0]         padded;
    logic [CNTW-1:0]       cnt_next [NG];
    logic [CNTW-1:0]       cnt_reg  [NG];
    logic [RANK_BITS-1:0]  rank_reg;
    logic                  st1_reg;
    logic                  st2_reg;
    logic [GW-1:0]         grp_next;
    logic [GW-1:0]         grp_reg;
    logic [SUBW-1:0]       sub_next;
    logic [SUBW-1:0]       sub_reg;
    logic                  found_next;
    logic                  found_reg;
    logic [GROUP_BITS-1:0] grp_bits;
    logic                  bit_hit;
    logic [SUBW-1:0]       bit_idx;

    assign padded = PW'(full);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            cnt_next[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++)
            begin
                cnt_next[g] = cnt_next[g] + CNTW'(padded[g*GROUP_BITS + b]);
            end
        end
    end

    always_comb
    begin
        logic [OCC_BITS-1:0] run;
        run        = '0;
        grp_next   = '0;
        sub_next   = '0;
        found_next = 1'b0;
        for (int g = 0; g < NG; g++)
        begin
            if (!found_next && (OCC_BITS'(rank_reg) < run + OCC_BITS'(cnt_reg[g])))
            begin
                found_next = 1'b1;
                grp_next   = GW'(g);
                sub_next   = SUBW'(OCC_BITS'(rank_reg) - run);
            end
            run = run + OCC_BITS'(cnt_reg[g]);
        end
    end

    assign grp_bits = padded[grp_reg*GROUP_BITS +: GROUP_BITS];

    always_comb
    begin
        logic [CNTW-1:0] seen;
        seen    = '0;
        bit_hit = 1'b0;
        bit_idx = '0;
        for (int b = 0; b < GROUP_BITS; b++)
        begin
            if (grp_bits[b] && !bit_hit && (seen == CNTW'(sub_reg)))
            begin
                bit_hit = 1'b1;
                bit_idx = SUBW'(b);
            end
            seen = seen + CNTW'(grp_bits[b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= 1'b0;
            st2_reg <= 1'b0;
        end
        else
        begin
            st1_reg <= start;
            st2_reg <= st1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg  <= cnt_next;
            rank_reg <= rank;
        end
        if (st1_reg)
        begin
            grp_reg   <= grp_next;
            sub_reg   <= sub_next;
            found_reg <= found_next;
        end
    end

    assign res.done  = st2_reg;
    assign res.found = found_reg && bit_hit;
    assign res.key   = KEY_BITS'({grp_reg, bit_idx});

endmodule

`default_nettype wire

// File: rtl/direct_access_symbol_table_top.sv
// ============================================================================
// direct_access_symbol_table_top
// Sequence: insert, delete and search are registered, then wait for a free output;
// select runs popcount, group walk, bit walk with value read, then the result.
// Flow: one transaction at a time; a new item is taken only in idle, after the last
// result is loaded into the output registers, so a stalled output delays the next item.
// Reset: all full marks and the count clear at once; values stay unwritten.
// ============================================================================
`default_nettype none

module direct_access_symbol_table_top #(
    parameter int SLOTS      = dast_pkg::DEFAULT_SLOTS,
    parameter int VALUE_BITS = dast_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // slot_key, item_value, rank
    input  logic [dast_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // func
    input  logic [dast_pkg::FUNC_BITS-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found_key, found_value, occupied
    output logic [dast_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // hit
    output logic [0:0]                         m_tuser
);
    import dast_pkg::*;

    localparam int LIVE = (SLOTS < (2 ** KEY_BITS)) ? SLOTS : (2 ** KEY_BITS);
    localparam int LAW  = $clog2(LIVE);
    localparam int CW   = $clog2(LIVE + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [LIVE-1:0]            full_reg;
    logic [LIVE-1:0]            full_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [VALUE_BITS-1:0]      mem [LIVE];
    logic [VALUE_BITS-1:0]      rdata_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [LAW-1:0]             mem_addr;
    logic                       accept;
    func_t                      func;
    logic [KEY_BITS-1:0]        key_in;
    logic [LAW-1:0]             key_addr;
    logic                       in_range;
    logic [RANK_BITS-1:0]       rank_in;
    logic [VALUE_BITS-1:0]      wdata;
    sel_res_t                   sel;
    logic                       res_hit_reg;
    logic                       res_hit_next;
    logic [KEY_BITS-1:0]        res_key_reg;
    logic [KEY_BITS-1:0]        res_key_next;
    logic                       out_free;
    logic                       out_load;
    logic                       m_tvalid_reg;
    logic                       out_hit_reg;
    logic [KEY_BITS-1:0]        out_key_reg;
    logic [VALUE_PORT_BITS-1:0] out_value_reg;
    logic [OCC_BITS-1:0]        out_occ_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign key_in   = s_tdata[KEY_LSB +: KEY_BITS];
    assign key_addr = key_in[LAW-1:0];
    assign rank_in  = s_tdata[RANK_LSB +: RANK_BITS];
    assign wdata    = VALUE_BITS'(s_tdata[VALUE_LSB +: VALUE_PORT_BITS]);
    assign in_range = (KEY_BITS+1)'(key_in) < (KEY_BITS+1)'(LIVE);

    dast_rank #(
        .LIVE (LIVE)
    ) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (func == FUNC_SELECT)),
        .full  (full_reg),
        .rank  (rank_in),
        .res   (sel)
    );

    assign mem_we   = accept && (func == FUNC_INSERT) && in_range;
    assign mem_re   = (accept && (func == FUNC_SEARCH)) || sel.done;
    assign mem_addr = sel.done ? sel.key[LAW-1:0] : key_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        full_next  = full_reg;
        count_next = count_reg;
        if (accept && in_range)
        begin
            case (func)
                FUNC_INSERT:
                begin
                    full_next[key_addr] = 1'b1;
                    if (!full_reg[key_addr])
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_DELETE:
                begin
                    full_next[key_addr] = 1'b0;
                    if (full_reg[key_addr])
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    full_next  = full_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_WAIT) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        res_hit_next = res_hit_reg;
        res_key_next = res_key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_hit_next = (func == FUNC_SEARCH) && in_range && full_reg[key_addr];
                    res_key_next = key_in;
                    state_next   = (func == FUNC_SELECT) ? ST_SEL : ST_WAIT;
                end
            end
            ST_SEL:
            begin
                if (sel.done)
                begin
                    res_hit_next = sel.found;
                    res_key_next = sel.key;
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            full_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            count_reg <= count_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_hit_reg <= res_hit_next;
        res_key_reg <= res_key_next;
        if (out_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_key_reg   <= res_hit_reg ? res_key_reg : '0;
            out_value_reg <= res_hit_reg ? VALUE_PORT_BITS'(rdata_reg) : '0;
            out_occ_reg   <= OCC_BITS'(count_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_occ_reg, out_value_reg, out_key_reg});

`include "direct_access_symbol_table_top_assert.svh"

    `DAST_ASSERT(a_count_bound, (count_reg <= CW'(LIVE)), "full count exceeds slots")
    `DAST_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (state_reg == ST_IDLE), "not idle after reset")
    `DAST_ASSERT(a_insert_marks, (accept && (func == FUNC_INSERT) && in_range) |=> full_reg[$past(key_addr)], "insert did not mark slot full")
    `DAST_ASSERT(a_miss_zero, (m_tvalid && !m_tuser[0]) |-> ((out_key_reg == '0) && (out_value_reg == '0)), "miss result carries data")
    `DAST_ASSERT(a_sel_in_sel, sel.done |-> (state_reg == ST_SEL), "rank result outside select")

endmodule

`default_nettype wire
